>>> hdl/hsv565_pkg.sv
// Shared types, constants and codes for the HSV to RGB565 color converter.
`default_nettype none

package hsv565_pkg;

    localparam int CHAN_W      = 8;
    localparam int SECTOR_W    = 3;
    localparam int SECTOR_SIZE = 43;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam logic [SECTOR_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAG_RED = 3'd5;

    typedef struct packed {
        logic load_mul;
        logic load_lvl;
    } hsv565_ctrl_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   frac;
        logic [CHAN_W-1:0]   sat;
        logic [CHAN_W-1:0]   val;
    } hsv565_s1_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [CHAN_W-1:0]   val;
        logic [CHAN_W-1:0]   p;
        logic [CHAN_W-1:0]   q;
        logic [CHAN_W-1:0]   t;
    } hsv565_lvl_t;

endpackage

`default_nettype wire

>>> hdl/hsv_to_rgb565.sv
// Top level of the HSV to RGB565 color converter with its stream handshake.
`default_nettype none

// Converts one 8-bit hue, saturation and value word into an RGB565 color and the three
// 8-bit channels. The pipeline has four register stages (sector decode, first multiply,
// second multiply, channel select and pack), and one word can enter in every cycle while
// the output is not stalled. Each stage moves on whenever the stage after it is empty or
// moving, so a stall on the output only holds the words that are queued behind it and
// bubbles are squeezed out.

module hsv_to_rgb565
    import hsv565_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0 up: hue[7:0], saturation[15:8], brightness[23:16].
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Fields from bit 0 up: color565[15:0], red[23:16], green[31:24], blue[39:32].
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic s1_vld_reg, s1_vld_next;
    logic s2_vld_reg, s2_vld_next;
    logic s3_vld_reg, s3_vld_next;
    logic out_vld_reg, out_vld_next;

    logic s1_ready, s2_ready, s3_ready, out_ready;

    logic [CHAN_W-1:0]   hue, saturation, brightness;
    logic [SECTOR_W-1:0] sector;
    logic [CHAN_W-1:0]   base;
    logic [CHAN_W-1:0]   rem;
    logic [CHAN_W-1:0]   frac;

    hsv565_s1_t   s1_reg;
    hsv565_ctrl_t ctrl;
    hsv565_lvl_t  lvl;

    logic [CHAN_W-1:0]   red_next, green_next, blue_next;
    logic [CHAN_W-1:0]   red_reg, green_reg, blue_reg;
    logic [2*CHAN_W-1:0] color_reg;

    assign hue        = s_axis_tdata[CHAN_W-1:0];
    assign saturation = s_axis_tdata[2*CHAN_W-1:CHAN_W];
    assign brightness = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

    assign out_ready = !out_vld_reg || m_axis_tready;
    assign s3_ready  = !s3_vld_reg || out_ready;
    assign s2_ready  = !s2_vld_reg || s3_ready;
    assign s1_ready  = !s1_vld_reg || s2_ready;

    assign s_axis_tready = s1_ready;

    assign s1_vld_next  = s1_ready ? s_axis_tvalid : s1_vld_reg;
    assign s2_vld_next  = s2_ready ? s1_vld_reg : s2_vld_reg;
    assign s3_vld_next  = s3_ready ? s2_vld_reg : s3_vld_reg;
    assign out_vld_next = out_ready ? s3_vld_reg : out_vld_reg;

    always_comb
    begin
        if (hue < CHAN_W'(SECTOR_SIZE))
        begin
            sector = SEC_RED_YEL;
            base   = '0;
        end
        else if (hue < CHAN_W'(2*SECTOR_SIZE))
        begin
            sector = SEC_YEL_GRN;
            base   = CHAN_W'(SECTOR_SIZE);
        end
        else if (hue < CHAN_W'(3*SECTOR_SIZE))
        begin
            sector = SEC_GRN_CYN;
            base   = CHAN_W'(2*SECTOR_SIZE);
        end
        else if (hue < CHAN_W'(4*SECTOR_SIZE))
        begin
            sector = SEC_CYN_BLU;
            base   = CHAN_W'(3*SECTOR_SIZE);
        end
        else if (hue < CHAN_W'(5*SECTOR_SIZE))
        begin
            sector = SEC_BLU_MAG;
            base   = CHAN_W'(4*SECTOR_SIZE);
        end
        else
        begin
            sector = SEC_MAG_RED;
            base   = CHAN_W'(5*SECTOR_SIZE);
        end
        rem  = hue - base;
        frac = (rem << 2) + (rem << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg.sector <= sector;
            s1_reg.frac   <= frac;
            s1_reg.sat    <= saturation;
            s1_reg.val    <= brightness;
        end
    end

    assign ctrl.load_mul = s2_ready;
    assign ctrl.load_lvl = s3_ready;

    hsv565_levels u_levels
    (
        .clk  (clk),
        .ctrl (ctrl),
        .s1   (s1_reg),
        .lvl  (lvl)
    );

    always_comb
    begin
        case (lvl.sector)
            SEC_RED_YEL:
            begin
                red_next   = lvl.val;
                green_next = lvl.t;
                blue_next  = lvl.p;
            end
            SEC_YEL_GRN:
            begin
                red_next   = lvl.q;
                green_next = lvl.val;
                blue_next  = lvl.p;
            end
            SEC_GRN_CYN:
            begin
                red_next   = lvl.p;
                green_next = lvl.val;
                blue_next  = lvl.t;
            end
            SEC_CYN_BLU:
            begin
                red_next   = lvl.p;
                green_next = lvl.q;
                blue_next  = lvl.val;
            end
            SEC_BLU_MAG:
            begin
                red_next   = lvl.t;
                green_next = lvl.p;
                blue_next  = lvl.val;
            end
            default:
            begin
                red_next   = lvl.val;
                green_next = lvl.p;
                blue_next  = lvl.q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            color_reg <= {red_next[7:3], green_next[7:2], blue_next[7:3]};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg, color_reg};

    // A full pipeline with a stalled output must refuse new words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && s2_vld_reg && s3_vld_reg && out_vld_reg && !m_axis_tready)
        |-> !s_axis_tready)
    else $error("input accepted while the pipeline is full and stalled");

    // An accepted word always occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> s1_vld_reg)
    else $error("accepted word was lost at the first stage");

    // The packed color must agree with the unpacked channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:11] == m_axis_tdata[23:19]
                           && m_axis_tdata[10:5] == m_axis_tdata[31:26]
                           && m_axis_tdata[4:0] == m_axis_tdata[39:35]))
    else $error("packed color does not match the channel values");

endmodule

`default_nettype wire

>>> hdl/hsv565_levels.sv
// Multiply stages that form the p, q and t levels from a decoded hue sector.
`default_nettype none

module hsv565_levels
    import hsv565_pkg::*;
(
    input  wire logic         clk,
    input  wire hsv565_ctrl_t ctrl,
    input  wire hsv565_s1_t   s1,
    output hsv565_lvl_t       lvl
);

    logic [SECTOR_W-1:0] s2_sector_reg;
    logic [CHAN_W-1:0]   s2_val_reg;
    logic [CHAN_W-1:0]   s2_p_reg;
    logic [CHAN_W-1:0]   s2_sf_reg;
    logic [CHAN_W-1:0]   s2_st_reg;

    logic [2*CHAN_W-1:0] p_prod;
    logic [2*CHAN_W-1:0] sf_prod;
    logic [2*CHAN_W-1:0] st_prod;
    logic [2*CHAN_W-1:0] q_prod;
    logic [2*CHAN_W-1:0] t_prod;

    hsv565_lvl_t lvl_reg;

    always_comb
    begin
        p_prod  = (2*CHAN_W)'(s1.val) * (2*CHAN_W)'(CHAN_MAX - s1.sat);
        sf_prod = (2*CHAN_W)'(s1.sat) * (2*CHAN_W)'(s1.frac);
        st_prod = (2*CHAN_W)'(s1.sat) * (2*CHAN_W)'(CHAN_MAX - s1.frac);
        q_prod  = (2*CHAN_W)'(s2_val_reg) * (2*CHAN_W)'(CHAN_MAX - s2_sf_reg);
        t_prod  = (2*CHAN_W)'(s2_val_reg) * (2*CHAN_W)'(CHAN_MAX - s2_st_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            s2_sector_reg <= s1.sector;
            s2_val_reg    <= s1.val;
            s2_p_reg      <= p_prod[2*CHAN_W-1:CHAN_W];
            s2_sf_reg     <= sf_prod[2*CHAN_W-1:CHAN_W];
            s2_st_reg     <= st_prod[2*CHAN_W-1:CHAN_W];
        end
        if (ctrl.load_lvl)
        begin
            lvl_reg.sector <= s2_sector_reg;
            lvl_reg.val    <= s2_val_reg;
            lvl_reg.p      <= s2_p_reg;
            lvl_reg.q      <= q_prod[2*CHAN_W-1:CHAN_W];
            lvl_reg.t      <= t_prod[2*CHAN_W-1:CHAN_W];
        end
    end

    assign lvl = lvl_reg;

endmodule

`default_nettype wire
